@@ design/uuidp_pkg.sv @@
// Shared types and constants for the UUID text parser.
// No dependencies; used by uuidp_decode and uuid_text_to_bytes_parser_top.
package uuidp_pkg;

    localparam int unsigned PosW    = 6;
    localparam int unsigned NibW    = 4;
    localparam int unsigned IdxW    = 4;
    localparam int unsigned CharW   = 8;

    localparam logic [PosW-1:0]  TextLen   = 6'd36;
    localparam logic [PosW-1:0]  LastPos   = 6'd35;
    localparam logic [PosW-1:0]  DashPos0  = 6'd8;
    localparam logic [PosW-1:0]  DashPos1  = 6'd13;
    localparam logic [PosW-1:0]  DashPos2  = 6'd18;
    localparam logic [PosW-1:0]  DashPos3  = 6'd23;

    localparam logic [CharW-1:0] ChDash    = 8'h2D;
    localparam logic [CharW-1:0] ChZero    = 8'h30;
    localparam logic [CharW-1:0] ChNine    = 8'h39;
    localparam logic [CharW-1:0] ChLowA    = 8'h61;
    localparam logic [CharW-1:0] ChLowF    = 8'h66;

    // status codes carried with the done flag
    localparam logic StatusOk      = 1'b0;
    localparam logic StatusInvalid = 1'b1;

    // per-character classification handed from the decoder to the top
    typedef struct packed {
        logic            beyond;    // position at or past the text length
        logic            dash_slot; // position must hold a dash
        logic            is_dash;
        logic            is_hex;    // lowercase hex digit
        logic [NibW-1:0] nibble;
        logic            low_digit; // second digit of a pair
        logic [IdxW-1:0] byte_idx;
    } t_char_info;

endpackage

@@ design/uuidp_decode.sv @@
// Character classifier: hex value, dash check and byte index from the position.
// Depends on uuidp_pkg.
module uuidp_decode (
    input  logic [uuidp_pkg::CharW-1:0] i_char,
    input  logic [uuidp_pkg::PosW-1:0]  i_pos,
    output uuidp_pkg::t_char_info       o_info
);

    logic                       w_digit;
    logic                       w_alpha;
    logic [uuidp_pkg::CharW-1:0] w_dig_off;
    logic [uuidp_pkg::CharW-1:0] w_alp_off;
    logic [uuidp_pkg::PosW-1:0]  w_hex_idx;
    logic [uuidp_pkg::PosW-1:0]  w_skip;

    assign w_digit   = (i_char >= uuidp_pkg::ChZero) && (i_char <= uuidp_pkg::ChNine);
    assign w_alpha   = (i_char >= uuidp_pkg::ChLowA) && (i_char <= uuidp_pkg::ChLowF);
    assign w_dig_off = i_char - uuidp_pkg::ChZero;
    assign w_alp_off = i_char - uuidp_pkg::ChLowA + 8'd10;

    // dashes already passed before this position
    assign w_skip = {5'd0, (i_pos > uuidp_pkg::DashPos0)}
                  + {5'd0, (i_pos > uuidp_pkg::DashPos1)}
                  + {5'd0, (i_pos > uuidp_pkg::DashPos2)}
                  + {5'd0, (i_pos > uuidp_pkg::DashPos3)};
    assign w_hex_idx = i_pos - w_skip;

    always_comb begin
        o_info.beyond    = (i_pos >= uuidp_pkg::TextLen);
        o_info.dash_slot = (i_pos == uuidp_pkg::DashPos0) || (i_pos == uuidp_pkg::DashPos1)
                        || (i_pos == uuidp_pkg::DashPos2) || (i_pos == uuidp_pkg::DashPos3);
        o_info.is_dash   = (i_char == uuidp_pkg::ChDash);
        o_info.is_hex    = w_digit || w_alpha;
        o_info.nibble    = w_digit ? w_dig_off[uuidp_pkg::NibW-1:0]
                                   : w_alp_off[uuidp_pkg::NibW-1:0];
        o_info.low_digit = w_hex_idx[0];
        o_info.byte_idx  = w_hex_idx[uuidp_pkg::IdxW:1];
    end

endmodule

@@ design/uuid_text_to_bytes_parser_top.sv @@
// Top level of the UUID text parser: string state, result register, handshakes.
// Depends on uuidp_pkg and uuidp_decode.
//
//  channel  | dir | tdata                          | tuser                   | tlast
//  s_axis   | in  | [7:0] char_code                | -                       | end_of_text
//  m_axis   | out | [7:0] data_byte,[11:8] byte_index | [0] byte_valid,[1] status | done_res
//
// One character per cycle; its result (if any) appears on m_axis the cycle after.
// The result path holds one register: character state updates and the result register load
// in the same edge. s_axis_tready drops only while a result waits and m_axis_tready
// is low. Synchronous active-low reset clears the string state and the result valid.
module uuid_text_to_bytes_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] byte_index, zero pad
    output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] status
    output logic        m_axis_tlast    // done_res
);

    uuidp_pkg::t_char_info w_info;

    logic [uuidp_pkg::PosW-1:0] r_pos, n_pos;
    logic [uuidp_pkg::NibW-1:0] r_high, n_high;
    logic                       r_err, n_err;

    logic                       r_out_valid, n_out_valid;
    logic [7:0]                 r_byte;
    logic [uuidp_pkg::IdxW-1:0] r_idx;
    logic                       r_bvalid;
    logic                       r_done;
    logic                       r_status;

    logic w_accept;
    logic w_bad_char;
    logic w_emit;
    logic w_result;
    logic w_err_all;

    uuidp_decode u_decode (
        .i_char (s_axis_tdata),
        .i_pos  (r_pos),
        .o_info (w_info)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_bad_char = w_info.beyond
                     || (w_info.dash_slot && !w_info.is_dash)
                     || (!w_info.dash_slot && !w_info.is_hex);
    assign w_emit     = !w_bad_char && !w_info.dash_slot && w_info.low_digit && !r_err;
    assign w_result   = w_emit || s_axis_tlast;
    assign w_err_all  = r_err || w_bad_char;

    always_comb begin
        n_pos  = r_pos;
        n_high = r_high;
        n_err  = r_err;
        if (w_accept) begin
            if (s_axis_tlast) begin
                n_pos  = '0;
                n_high = '0;
                n_err  = 1'b0;
            end else begin
                n_err = w_err_all;
                if (!w_info.beyond) begin
                    n_pos = r_pos + 6'd1;
                end
                if (!w_bad_char && !w_info.dash_slot && !w_info.low_digit) begin
                    n_high = w_info.nibble;
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept && w_result) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_high      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_high      <= n_high;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded with each produced item
    always_ff @(posedge i_clk) begin
        if (w_accept && w_result) begin
            r_byte   <= w_emit ? {r_high, w_info.nibble} : 8'd0;
            r_idx    <= w_emit ? w_info.byte_idx : '0;
            r_bvalid <= w_emit;
            r_done   <= s_axis_tlast;
            if (s_axis_tlast && (w_err_all || (r_pos != uuidp_pkg::LastPos))) begin
                r_status <= uuidp_pkg::StatusInvalid;
            end else begin
                r_status <= uuidp_pkg::StatusOk;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_idx, r_byte};
    assign m_axis_tuser  = {r_status, r_bvalid};
    assign m_axis_tlast  = r_done;

    a_pos_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= uuidp_pkg::TextLen)
        else $error("character position beyond text length");

    a_last_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tlast |=> (r_pos == '0) && !r_err && r_out_valid)
        else $error("string state not cleared after final item");

    a_status_with_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == uuidp_pkg::StatusInvalid) |-> r_done)
        else $error("invalid status without done");

    a_no_byte_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_bvalid |-> (r_byte == 8'd0) && (r_idx == '0))
        else $error("byte fields set without a byte");

    a_no_emit_after_err : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_err |=> !(r_out_valid && r_bvalid))
        else $error("byte emitted after an error");

endmodule
